// ===== hw/rtl/mcdf_pkg.sv =====
package mcdf_pkg;

   localparam int IDX_W = 20;
   localparam int ID_W  = 12;
   localparam int ID_CAPACITY = 4096;

   typedef struct packed {
      logic [IDX_W-1:0] position_index;
      logic [IDX_W-1:0] texcoord_index;
      logic [IDX_W-1:0] normal_ref;
      logic             face_start;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  vertex_id;
      logic             is_new;
      logic [IDX_W-1:0] new_position_index;
      logic [IDX_W-1:0] new_texcoord_index;
      logic [IDX_W-1:0] new_normal_index;
      logic             table_full;
      logic             last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_EMIT_ANCHOR,
      ST_EMIT_PRIOR,
      ST_EMIT_OWN
   } state_type;

endpackage

// ===== hw/rtl/mcdf_req_if.sv =====
interface mcdf_req_if;
   import mcdf_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mcdf_rsp_if.sv =====
interface mcdf_rsp_if;
   import mcdf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mcdf_ram.sv =====
module mcdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/mesh_corner_dedup_fan_indexer.sv =====
// Deduplicates polygon corners into vertex ids and fans faces into triangles.
// One corner is taken at a time. The slot table is a memory with one read and
// one write port and a registered read. The read address is the next probe
// slot, so the compare walks the linear-probe sequence one slot per probe.
// Each accepted corner is hashed, then probed 1..PROBE_LIMIT times, then gives
// its results (one, or three from the fourth corner of a face on), and the
// block returns to idle, where the next corner is taken. A stalled result sink
// holds the block in its emit states. Slot-valid bits are cleared by a pass
// over every slot of the table after reset, during which no corner is
// accepted. Results wait in an output register and are taken through the
// usual valid/ready handshake.
module mesh_corner_dedup_fan_indexer #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int INDEX_WIDTH   = 20,
   parameter int PROBE_LIMIT   = 8
) (
   input logic clock,
   input logic reset,
   mcdf_req_if.sink   req,
   mcdf_rsp_if.source rsp
);
   import mcdf_pkg::*;

   localparam int AW  = $clog2(TABLE_ENTRIES);
   localparam int KW  = 3 * INDEX_WIDTH;
   localparam int PCW = $clog2(PROBE_LIMIT + 1);
   localparam int SW  = 1 + KW + ID_W;

   state_type state_ff, state_in;

   logic [INDEX_WIDTH-1:0] p_ff, t_ff, n_ff;
   logic                   start_ff;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [PCW-1:0]         probe_ff, probe_in;
   logic [AW:0]            clr_ff;
   logic                   clearing;
   logic [ID_W:0]          next_free_ff;
   logic [ID_W-1:0]        anchor_ff, prior_ff, own_ff;
   logic [1:0]             count_ff;
   logic                   fresh_ff, full_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_data, rd_data;
   logic          rd_valid;
   logic [KW-1:0] rd_key, key;
   logic [ID_W-1:0] rd_id;
   logic [31:0]   h;
   logic          emit;
   rsp_type       emit_data;
   logic          resolve;
   logic          hit, miss_room, give_up;
   logic [1:0]    cnt_eff;

   assign clearing = !clr_ff[AW];
   assign key = {p_ff, t_ff, n_ff};
   assign {rd_valid, rd_key, rd_id} = rd_data;

   always_comb begin
      h = 32'(p_ff) * 32'h9E3779B1;
      h = h ^ (32'(t_ff) * 32'h85EBCA77);
      h = h ^ (32'(n_ff) * 32'hC2B2AE3D);
      h = h ^ (h >> 15);
   end

   // address the slot that the next cycle compares
   mcdf_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot_in),
      .rd_data (rd_data)
   );

   assign resolve   = (state_ff == ST_CHECK);
   assign hit       = rd_valid && (rd_key == key);
   assign miss_room = !rd_valid && (next_free_ff < (ID_W+1)'(ID_CAPACITY));
   assign give_up   = !rd_valid || (32'(probe_ff) + 1 >= PROBE_LIMIT);
   assign cnt_eff   = start_ff ? 2'd0 : count_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = {1'b1, key, next_free_ff[ID_W-1:0]};
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = '0;
      end else if (resolve && miss_room) begin
         wr_en = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      probe_in = probe_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && !clearing) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            slot_in  = AW'(h);
            probe_in = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit || give_up) begin
               state_in = (cnt_eff == 2'd3) ? ST_EMIT_ANCHOR : ST_EMIT_OWN;
            end else begin
               slot_in  = slot_ff + AW'(1);
               probe_in = probe_ff + PCW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_EMIT_ANCHOR: if (!rsp_valid_ff || rsp.ready) state_in = ST_EMIT_PRIOR;
         ST_EMIT_PRIOR:  if (!rsp_valid_ff || rsp.ready) state_in = ST_EMIT_OWN;
         ST_EMIT_OWN:    if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      emit = 1'b0;
      emit_data = '0;
      case (state_ff)
         ST_EMIT_ANCHOR: begin
            emit = !rsp_valid_ff || rsp.ready;
            emit_data.vertex_id = anchor_ff;
         end
         ST_EMIT_PRIOR: begin
            emit = !rsp_valid_ff || rsp.ready;
            emit_data.vertex_id = prior_ff;
         end
         ST_EMIT_OWN: begin
            emit = !rsp_valid_ff || rsp.ready;
            emit_data.vertex_id  = own_ff;
            emit_data.is_new     = fresh_ff;
            emit_data.table_full = full_ff;
            emit_data.last       = 1'b1;
            if (fresh_ff) begin
               emit_data.new_position_index = IDX_W'(p_ff);
               emit_data.new_texcoord_index = IDX_W'(t_ff);
               emit_data.new_normal_index   = IDX_W'(n_ff);
            end
         end
         default: ;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !clearing;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ff       <= '0;
         next_free_ff <= '0;
         anchor_ff    <= '0;
         prior_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + (AW+1)'(1);
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (resolve && (hit || give_up)) begin
            if (miss_room) next_free_ff <= next_free_ff + (ID_W+1)'(1);
            if (cnt_eff == 2'd0) begin
               anchor_ff <= hit ? rd_id : (miss_room ? next_free_ff[ID_W-1:0] : '0);
               count_ff  <= 2'd1;
            end else if (cnt_eff != 2'd3) begin
               count_ff  <= cnt_eff + 2'd1;
            end
         end
         // prior updates after the fan results have read it
         if (state_ff == ST_EMIT_OWN && emit) prior_ff <= own_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         p_ff     <= req.data.position_index[INDEX_WIDTH-1:0];
         t_ff     <= req.data.texcoord_index[INDEX_WIDTH-1:0];
         n_ff     <= req.data.normal_ref[INDEX_WIDTH-1:0];
         start_ff <= req.data.face_start;
      end
      if (resolve && (hit || give_up)) begin
         own_ff   <= hit ? rd_id : (miss_room ? next_free_ff[ID_W-1:0] : '0);
         fresh_ff <= !hit && miss_room;
         full_ff  <= !hit && !miss_room;
      end
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      if (emit) rsp_ff <= emit_data;
   end
endmodule

// ===== hw/rtl/mcdf_checker.sv =====
module mcdf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input mcdf_pkg::rsp_type rsp_data
);
   import mcdf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_new_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_new && rsp_data.table_full))
      else $error("new and full together");

   a_fan_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !rsp_data.is_new && !rsp_data.table_full)
      else $error("fan result carries own-id flags");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second corner taken before first resolved");
endmodule

bind mesh_corner_dedup_fan_indexer mcdf_checker u_mcdf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
